FILE: hdl/rsl_pkg.sv
// Package with the constants, types and the square-root step shared by the spotlight pipeline.
`timescale 1ns / 1ps

package rsl_pkg;

	localparam int COORD_BITS  = 12;
	localparam int CENTER_BITS = 14;
	localparam int LUM_BITS    = 16;
	localparam int DIFF_BITS   =
		((CENTER_BITS > COORD_BITS + 1) ? CENTER_BITS : COORD_BITS + 1) + 1;

	localparam int NEAR_BITS = 8;
	localparam int D2_BITS   = 2 * NEAR_BITS;
	localparam int RADIUS    = 160;
	localparam int RADIUS_SQ = 25600;

	localparam int ROOT_BITS       = 12;
	localparam int RAD_BITS        = 2 * ROOT_BITS;
	localparam int REM_BITS        = ROOT_BITS + 3;
	localparam int SQRT_STAGES     = 4;
	localparam int STEPS_PER_STAGE = ROOT_BITS / SQRT_STAGES;
	localparam int DQ_LIMIT        = 2560;

	localparam int SLOPE_BITS  = 15;
	localparam logic [SLOPE_BITS-1:0] SLOPE = 15'd20972;
	localparam int SLOPE_SHIFT = 10;
	localparam int PROD_BITS   = ROOT_BITS + SLOPE_BITS;
	localparam int SCALE_BITS  = 17;
	localparam logic [SCALE_BITS-1:0] UNIT_SCALE = 17'd65536;
	localparam logic [SCALE_BITS-1:0] FAR_SCALE  = 17'd13107;

	localparam int CFG_ADDR_BITS = 1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_X = 1'b0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_Y = 1'b1;

	typedef struct packed {
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		logic [RAD_BITS-1:0]  rad;
	} sqrt_state_t;

	typedef struct packed {
		logic                near;
		logic [LUM_BITS-1:0] lum;
	} side_t;

	function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
		sqrt_state_t         r;
		logic [REM_BITS-1:0] cur;
		logic [REM_BITS-1:0] trial;
		cur   = {s.rem[REM_BITS-3:0], s.rad[RAD_BITS-1 -: 2]};
		trial = REM_BITS'({s.root, 2'b01});
		r.rad = {s.rad[RAD_BITS-3:0], 2'b00};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {s.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {s.root[ROOT_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

FILE: hdl/radial_spotlight_luminance.sv
// Top level of the radial spotlight: offsets, squared distance, square root, scale and product.
// An accepted input beat passes through the s1 and s2 registers, the square-root stages, s7 and the output register.
// Throughput is one beat per cycle; the whole pipeline advances together and holds on a stall.
// Input ready follows the output register: it is high when that register is empty or taken.
// Asynchronous active-low reset clears the valid bits and sets both center registers to zero.
`timescale 1ns / 1ps

module radial_spotlight_luminance (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rsl_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [rsl_pkg::CENTER_BITS-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rsl_pkg::COORD_BITS-1:0]    pixel_x,
	input  logic [rsl_pkg::COORD_BITS-1:0]    pixel_y,
	input  logic [rsl_pkg::LUM_BITS-1:0]      lum_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rsl_pkg::LUM_BITS-1:0]      lum_out
);

	logic signed [rsl_pkg::CENTER_BITS-1:0] center_x_q;
	logic signed [rsl_pkg::CENTER_BITS-1:0] center_y_q;

	logic en;

	logic signed [rsl_pkg::DIFF_BITS-1:0] diff_x;
	logic signed [rsl_pkg::DIFF_BITS-1:0] diff_y;
	logic [rsl_pkg::DIFF_BITS-1:0] abs_x;
	logic [rsl_pkg::DIFF_BITS-1:0] abs_y;

	logic                              vld_s1;
	logic                              near_s1;
	logic [rsl_pkg::NEAR_BITS-1:0]     dx_s1;
	logic [rsl_pkg::NEAR_BITS-1:0]     dy_s1;
	logic [rsl_pkg::LUM_BITS-1:0]      lum_s1;

	logic [rsl_pkg::D2_BITS-1:0] sq_x;
	logic [rsl_pkg::D2_BITS-1:0] sq_y;
	logic [rsl_pkg::D2_BITS-1:0] d2_sum;

	logic                        vld_s2;
	logic [rsl_pkg::D2_BITS-1:0] d2_s2;
	rsl_pkg::side_t              side_s2;

	logic                          vld_s6;
	logic [rsl_pkg::ROOT_BITS-1:0] dq_s6;
	rsl_pkg::side_t                side_s6;

	logic [rsl_pkg::PROD_BITS-1:0]  slope_prod;
	logic [rsl_pkg::SCALE_BITS-1:0] scale_nx;

	logic                           vld_s7;
	logic [rsl_pkg::SCALE_BITS-1:0] scale_s7;
	logic [rsl_pkg::LUM_BITS-1:0]   lum_s7;

	logic [rsl_pkg::LUM_BITS+rsl_pkg::SCALE_BITS-1:0] lum_prod;

	logic                         out_valid_q;
	logic [rsl_pkg::LUM_BITS-1:0] lum_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				rsl_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				rsl_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_comb begin
		diff_x = rsl_pkg::DIFF_BITS'(center_x_q) - $signed(rsl_pkg::DIFF_BITS'(pixel_x));
		diff_y = rsl_pkg::DIFF_BITS'(center_y_q) - $signed(rsl_pkg::DIFF_BITS'(pixel_y));
		abs_x  = diff_x[rsl_pkg::DIFF_BITS-1] ? $unsigned(-diff_x) : $unsigned(diff_x);
		abs_y  = diff_y[rsl_pkg::DIFF_BITS-1] ? $unsigned(-diff_y) : $unsigned(diff_y);
	end

	always_comb begin
		sq_x   = dx_s1 * dx_s1;
		sq_y   = dy_s1 * dy_s1;
		d2_sum = sq_x + sq_y;
	end

	always_comb begin
		slope_prod = rsl_pkg::PROD_BITS'(dq_s6) * rsl_pkg::PROD_BITS'(rsl_pkg::SLOPE);
		if (side_s6.near) begin
			scale_nx = rsl_pkg::UNIT_SCALE -
				slope_prod[rsl_pkg::SLOPE_SHIFT +: rsl_pkg::SCALE_BITS];
		end else begin
			scale_nx = rsl_pkg::FAR_SCALE;
		end
	end

	assign lum_prod = (rsl_pkg::LUM_BITS + rsl_pkg::SCALE_BITS)'(lum_s7) *
		(rsl_pkg::LUM_BITS + rsl_pkg::SCALE_BITS)'(scale_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s7      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			vld_s7      <= vld_s6;
			out_valid_q <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_s1      <= (abs_x < rsl_pkg::RADIUS) && (abs_y < rsl_pkg::RADIUS);
			dx_s1        <= abs_x[rsl_pkg::NEAR_BITS-1:0];
			dy_s1        <= abs_y[rsl_pkg::NEAR_BITS-1:0];
			lum_s1       <= lum_in;
			d2_s2        <= d2_sum;
			side_s2.near <= near_s1 && (d2_sum < rsl_pkg::RADIUS_SQ);
			side_s2.lum  <= lum_s1;
			scale_s7     <= scale_nx;
			lum_s7       <= side_s6.lum;
			lum_out_q    <= lum_prod[rsl_pkg::LUM_BITS +: rsl_pkg::LUM_BITS];
		end
	end

	rsl_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_d2    (d2_s2),
		.in_side  (side_s2),
		.out_vld  (vld_s6),
		.out_root (dq_s6),
		.out_side (side_s6)
	);

	assign out_valid = out_valid_q;
	assign lum_out   = lum_out_q;

	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 |-> (scale_s7 >= rsl_pkg::FAR_SCALE) && (scale_s7 <= rsl_pkg::UNIT_SCALE))
		else $error("Scale left its allowed range.");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && side_s6.near) |-> (dq_s6 < rsl_pkg::DQ_LIMIT))
		else $error("Square root exceeds the spotlight radius.");

	a_no_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s7) |=> (lum_out_q <= $past(lum_s7)))
		else $error("Output luminance exceeds input luminance.");

endmodule

FILE: hdl/rsl_isqrt.sv
// Pipelined integer square root of the scaled squared distance, with sideband carried alongside.
`timescale 1ns / 1ps

module rsl_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [rsl_pkg::D2_BITS-1:0]   in_d2,
	input  rsl_pkg::side_t                in_side,
	output logic                          out_vld,
	output logic [rsl_pkg::ROOT_BITS-1:0] out_root,
	output rsl_pkg::side_t                out_side
);

	rsl_pkg::sqrt_state_t sq_st_s   [rsl_pkg::SQRT_STAGES];
	rsl_pkg::side_t       sq_side_s [rsl_pkg::SQRT_STAGES];
	logic [rsl_pkg::SQRT_STAGES-1:0] sq_vld_s;

	rsl_pkg::sqrt_state_t st_in   [rsl_pkg::SQRT_STAGES];
	rsl_pkg::sqrt_state_t st_nx   [rsl_pkg::SQRT_STAGES];
	rsl_pkg::side_t       side_in [rsl_pkg::SQRT_STAGES];
	logic [rsl_pkg::SQRT_STAGES-1:0] vld_in;

	always_comb begin
		st_in[0].rem  = '0;
		st_in[0].root = '0;
		st_in[0].rad  = {in_d2, {(rsl_pkg::RAD_BITS - rsl_pkg::D2_BITS){1'b0}}};
		side_in[0]    = in_side;
		vld_in[0]     = in_vld;
		for (int i = 1; i < rsl_pkg::SQRT_STAGES; i++) begin
			st_in[i]   = sq_st_s[i-1];
			side_in[i] = sq_side_s[i-1];
			vld_in[i]  = sq_vld_s[i-1];
		end
	end

	for (genvar g = 0; g < rsl_pkg::SQRT_STAGES; g++) begin : g_stage
		always_comb begin
			rsl_pkg::sqrt_state_t t;
			t = st_in[g];
			for (int k = 0; k < rsl_pkg::STEPS_PER_STAGE; k++) begin
				t = rsl_pkg::sqrt_step(t);
			end
			st_nx[g] = t;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[g] <= 1'b0;
			end else if (en) begin
				sq_vld_s[g] <= vld_in[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_st_s[g]   <= st_nx[g];
				sq_side_s[g] <= side_in[g];
			end
		end
	end

	assign out_vld  = sq_vld_s[rsl_pkg::SQRT_STAGES-1];
	assign out_root = sq_st_s[rsl_pkg::SQRT_STAGES-1].root;
	assign out_side = sq_side_s[rsl_pkg::SQRT_STAGES-1];

endmodule

FILE: bench/spotlight_checker.sv
// Checker that predicts the attenuated luminance of each pixel beat and compares the outputs.
`timescale 1ns / 1ps

module spotlight_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rsl_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [rsl_pkg::CENTER_BITS-1:0]   cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [rsl_pkg::COORD_BITS-1:0]    pixel_x,
	input  logic [rsl_pkg::COORD_BITS-1:0]    pixel_y,
	input  logic [rsl_pkg::LUM_BITS-1:0]      lum_in,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [rsl_pkg::LUM_BITS-1:0]      lum_out,
	output int                                fail_count,
	output int                                pending,
	output int                                near_beats,
	output int                                checked_beats
);
	import rsl_pkg::*;

	typedef struct {
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic [LUM_BITS-1:0]   lum;
	} spot_result_t;

	logic [CENTER_BITS-1:0] centre_x;
	logic [CENTER_BITS-1:0] centre_y;
	spot_result_t           predicted_lum_q[$];

	function automatic int unsigned floor_root(input int unsigned v);
		int unsigned root;
		int unsigned step;
		root = 0;
		step = 32'h4000_0000;
		while (step > v)
			step = step >> 2;
		while (step != 0) begin
			if (v >= root + step) begin
				v = v - (root + step);
				root = (root >> 1) + step;
			end else begin
				root = root >> 1;
			end
			step = step >> 2;
		end
		return root;
	endfunction

	function automatic logic [LUM_BITS-1:0] predict_spotlight(
		input logic [CENTER_BITS-1:0] cx_raw,
		input logic [CENTER_BITS-1:0] cy_raw,
		input logic [COORD_BITS-1:0]  px,
		input logic [COORD_BITS-1:0]  py,
		input logic [LUM_BITS-1:0]    lum,
		output bit                    near
	);
		int                cx;
		int                cy;
		int                dx;
		int                dy;
		int unsigned       d2;
		int unsigned       dq;
		int unsigned       scale;
		longint unsigned   prod;
		cx = $signed(cx_raw);
		cy = $signed(cy_raw);
		dx = cx - int'(px);
		dy = cy - int'(py);
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		scale = FAR_SCALE;
		near = 1'b0;
		if (dx < RADIUS && dy < RADIUS) begin
			d2 = dx * dx + dy * dy;
			if (d2 < RADIUS_SQ) begin
				near = 1'b1;
				dq = floor_root(d2 * 256);
				scale = UNIT_SCALE - ((dq * SLOPE) >> SLOPE_SHIFT);
			end
		end
		prod = longint'(lum) * scale;
		return LUM_BITS'(prod >> 16);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		spot_result_t item;
		spot_result_t head;
		bit           near;
		int           errs;
		if (!arst_n) begin
			centre_x = '0;
			centre_y = '0;
			predicted_lum_q.delete();
			fail_count <= 0;
			pending <= 0;
			near_beats <= 0;
			checked_beats <= 0;
		end else begin
			errs = 0;
			if (cfg_we) begin
				case (cfg_addr)
					REG_CENTER_X: centre_x = cfg_data;
					REG_CENTER_Y: centre_y = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (predicted_lum_q.size() == 0) begin
					$error("lum_out beat %0d arrived with no pixel outstanding", lum_out);
					errs++;
				end else begin
					head = predicted_lum_q.pop_front();
					if (lum_out !== head.lum) begin
						$error("lum_out mismatch at pixel (%0d,%0d): expected %0d, actual %0d",
							head.px, head.py, head.lum, lum_out);
						errs++;
					end
					checked_beats <= checked_beats + 1;
				end
			end
			if (in_valid && in_ready) begin
				item.px = pixel_x;
				item.py = pixel_y;
				item.lum = predict_spotlight(centre_x, centre_y, pixel_x, pixel_y, lum_in, near);
				predicted_lum_q.push_back(item);
				if (near)
					near_beats <= near_beats + 1;
			end
			fail_count <= fail_count + errs;
			pending <= predicted_lum_q.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// Top of the spotlight testbench: clock, reset, center settings, pixel stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
	import rsl_pkg::*;

	localparam int IDLE_PCT     = 9;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
	localparam int LUM_MAX      = (1 << LUM_BITS) - 1;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [CENTER_BITS-1:0]   cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic [COORD_BITS-1:0]    pixel_x;
	logic [COORD_BITS-1:0]    pixel_y;
	logic [LUM_BITS-1:0]      lum_in;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [LUM_BITS-1:0]      lum_out;

	int fail_count;
	int pending;
	int near_beats;
	int checked_beats;
	int stall_cycles = 0;
	int sent_beats = 0;
	int settings_used = 1;
	bit calm = 1'b0;

	radial_spotlight_luminance u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.lum_in   (lum_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lum_out  (lum_out)
	);

	spotlight_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.lum_in       (lum_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.lum_out      (lum_out),
		.fail_count   (fail_count),
		.pending      (pending),
		.near_beats   (near_beats),
		.checked_beats(checked_beats)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles + 1 >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_pixel(input int x, input int y, input int lum);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= COORD_BITS'(x);
		pixel_y <= COORD_BITS'(y);
		lum_in <= LUM_BITS'(lum);
		do
			@(posedge clk);
		while (!in_ready);
		sent_beats++;
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_centre(input int cx, input int cy);
		drain_pipe();
		cfg_we <= 1'b1;
		cfg_addr <= REG_CENTER_X;
		cfg_data <= CENTER_BITS'(cx);
		@(posedge clk);
		cfg_addr <= REG_CENTER_Y;
		cfg_data <= CENTER_BITS'(cy);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic int pick_coord(input int centre);
		int p;
		if ($urandom_range(0, 9) < 7)
			p = centre + int'($urandom_range(0, 340)) - 170;
		else
			p = $urandom_range(0, COORD_MAX);
		if (p < 0)
			p = 0;
		if (p > COORD_MAX)
			p = COORD_MAX;
		return p;
	endfunction

	function automatic int pick_lum();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return LUM_MAX;
			default: return $urandom_range(0, LUM_MAX);
		endcase
	endfunction

	task automatic run_phase(input int cx, input int cy, input int beats, input bit quiet);
		set_centre(cx, cy);
		calm = quiet;
		repeat (beats) send_pixel(pick_coord(cx), pick_coord(cy), pick_lum());
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_CENTER_X;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		lum_in = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The center sits at the origin after reset.
		send_pixel(0, 0, LUM_MAX);
		send_pixel(0, 0, 0);
		send_pixel(159, 0, LUM_MAX);
		send_pixel(160, 0, LUM_MAX);
		send_pixel(0, 160, 40000);
		send_pixel(113, 113, LUM_MAX);
		send_pixel(114, 113, LUM_MAX);
		send_pixel(COORD_MAX, COORD_MAX, LUM_MAX);
		send_pixel(1, 1, 12345);
		send_pixel(0, 159, 16'h8000);

		set_centre(-4096, 8191);
		send_pixel(0, COORD_MAX, LUM_MAX);
		send_pixel(COORD_MAX, 0, 16'h8001);

		set_centre(2048, 2048);
		send_pixel(2048, 2048, LUM_MAX);
		send_pixel(2207, 2048, LUM_MAX);
		send_pixel(1889, 2048, 16'hAAAA);
		send_pixel(2048, 2208, 16'h5555);
		send_pixel(2048, 1888, LUM_MAX);
		send_pixel(2161, 2161, LUM_MAX);
		send_pixel(2162, 2161, LUM_MAX);
		send_pixel(2207, 2065, LUM_MAX);
		send_pixel(2049, 2048, 1);

		run_phase(1000, 1500, 225, 1'b0);
		run_phase(-4096, -4096, 100, 1'b0);
		run_phase(100, 4000, 225, 1'b1);
		run_phase(8191, 8191, 100, 1'b0);
		run_phase(-50, 30, 225, 1'b0);
		run_phase(int'($urandom_range(0, 12287)) - 4096,
			int'($urandom_range(0, 12287)) - 4096, 225, 1'b0);
		run_phase($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 225, 1'b0);
		run_phase(COORD_MAX, COORD_MAX, 225, 1'b0);
		drain_pipe();

		$display("Checked %0d of %0d pixel beats under %0d center settings.",
			checked_beats, sent_beats, settings_used);
		$display("%0d beats fell inside the spotlight radius, the rest took the far scale.",
			near_beats);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
